[rtl/tbw_pkg.sv]
// types, widths and constants shared by the barycentric weight pipeline
package tbw_pkg;

	localparam int COORD_W   = 16;
	localparam int FRAC_BITS = 16;
	localparam int WEIGHT_W  = 32;

	// edge vectors, dot products and wide products
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int DOT_W  = 2 * COORD_W + 3;
	localparam int MAG_W  = DOT_W - 1;
	localparam int HALF_W = (MAG_W + 1) / 2;
	localparam int PART_W = 2 * HALF_W;
	localparam int SMUL_W = 2 * MAG_W + 1;
	localparam int DEN_W  = 2 * MAG_W;
	localparam int NUM_W  = SMUL_W + 1;
	localparam int NMAG_W = NUM_W - 1;

	// restoring divider
	localparam int QUO_W = WEIGHT_W + 1;
	localparam int REM_W = DEN_W + WEIGHT_W;

	// pipeline depth
	localparam int DOT_STAGES = 3;
	localparam int MUL_STAGES = 4;
	localparam int DIV_STAGES = QUO_W + 1;
	localparam int PIPE_DEPTH = DOT_STAGES + MUL_STAGES + 1 + DIV_STAGES + 2;

	typedef logic signed [COORD_W-1:0]  coord_t;
	typedef logic signed [WEIGHT_W-1:0] weight_t;
	typedef logic signed [DOT_W-1:0]    dot_t;
	typedef logic signed [SMUL_W-1:0]   smul_t;

	localparam weight_t W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
	localparam weight_t W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
		coord_t corner0_x;
		coord_t corner0_y;
		coord_t corner0_z;
		coord_t corner1_x;
		coord_t corner1_y;
		coord_t corner1_z;
		coord_t corner2_x;
		coord_t corner2_y;
		coord_t corner2_z;
	} tbw_query_t;

	typedef struct packed {
		weight_t weight0;
		weight_t weight1;
		weight_t weight2;
		logic    degenerate;
	} tbw_weights_t;

endpackage

[rtl/tbw_if.sv]
// valid/ready channels for query items and weight items
interface tbw_query_if import tbw_pkg::*; ();
	logic       valid;
	logic       ready;
	tbw_query_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tbw_weights_if import tbw_pkg::*; ();
	logic         valid;
	logic         ready;
	tbw_weights_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/triangle_barycentric_weights.sv]
// Barycentric weights of a query point against a 3D triangle.
// query channel: three corners and a point, signed Q8.8 coordinates.
// weights channel: weight0..2 in signed Q16.16, saturated, and a degenerate
// flag; a triangle with zero area gives the flag and all-zero weights.
// Every query item gives exactly one weights item, in order.
// The pipeline is made up of three stages of
// edge vectors and dot products, four of split wide multiplication, one for
// the Cramer numerators and denominator, one input stage plus one stage per
// quotient bit in the restoring dividers (33 bits, top bit flags overflow),
// then saturation and the weight0 stage.
// Throughput is one item per cycle while the receiver takes results; all stages move together.
// When the receiver holds off a valid result the whole pipeline stops and
// query.ready drops in the same cycle; nothing is lost or repeated.
// Reset clears only the valid bits; the block keeps no state between items.
module triangle_barycentric_weights import tbw_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	tbw_query_if.sink    query,
	tbw_weights_if.source weights
);

	localparam logic signed [WEIGHT_W+1:0] ONE_EXT = (WEIGHT_W+2)'(1) << FRAC_BITS;

	logic                    en;
	logic [PIPE_DEPTH-1:0]   valid_q;

	dot_t  d11, d12, d1p, d22, d2p;
	smul_t m11_22, m12_12, m22_1p, m12_2p, m11_2p, m12_1p;

	logic [DEN_W-1:0]        den_s8;
	logic signed [NUM_W-1:0] num1_s8, num2_s8;
	logic [NUM_W-1:0]        den_full;
	logic [NMAG_W-1:0]       mag1, mag2;
	logic                    degen_in;
	logic                    degen_dly_q [0:DIV_STAGES-1];

	logic [QUO_W-1:0] quo1, quo2;
	logic             neg1, neg2;
	weight_t          w1_s43, w2_s43;
	logic             degen_s43;
	tbw_weights_t     out_s44;
	logic signed [WEIGHT_W+1:0] w0_sum;

	assign en = !valid_q[PIPE_DEPTH-1] || weights.ready;
	assign query.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[PIPE_DEPTH-2:0], query.valid};
		end
	end

	tbw_dot u_dot (
		.clk (clk), .en (en), .q (query.data),
		.d11 (d11), .d12 (d12), .d1p (d1p), .d22 (d22), .d2p (d2p)
	);

	tbw_mul u_m11_22 (.clk (clk), .en (en), .a (d11), .b (d22), .p (m11_22));
	tbw_mul u_m12_12 (.clk (clk), .en (en), .a (d12), .b (d12), .p (m12_12));
	tbw_mul u_m22_1p (.clk (clk), .en (en), .a (d22), .b (d1p), .p (m22_1p));
	tbw_mul u_m12_2p (.clk (clk), .en (en), .a (d12), .b (d2p), .p (m12_2p));
	tbw_mul u_m11_2p (.clk (clk), .en (en), .a (d11), .b (d2p), .p (m11_2p));
	tbw_mul u_m12_1p (.clk (clk), .en (en), .a (d12), .b (d1p), .p (m12_1p));

	// denominator is never negative, so its low bits carry it exactly
	assign den_full = NUM_W'(m11_22) - NUM_W'(m12_12);

	always_ff @(posedge clk) begin
		if (en) begin
			den_s8  <= den_full[DEN_W-1:0];
			num1_s8 <= NUM_W'(m22_1p) - NUM_W'(m12_2p);
			num2_s8 <= NUM_W'(m11_2p) - NUM_W'(m12_1p);
		end
	end

	always_comb begin
		mag1 = num1_s8[NUM_W-1] ? NMAG_W'(-num1_s8) : NMAG_W'(num1_s8);
		mag2 = num2_s8[NUM_W-1] ? NMAG_W'(-num2_s8) : NMAG_W'(num2_s8);
		degen_in = (den_s8 == '0);
	end

	tbw_div u_div1 (
		.clk (clk), .en (en), .num_mag (mag1), .num_neg (num1_s8[NUM_W-1]),
		.den (den_s8), .quo (quo1), .neg (neg1)
	);

	tbw_div u_div2 (
		.clk (clk), .en (en), .num_mag (mag2), .num_neg (num2_s8[NUM_W-1]),
		.den (den_s8), .quo (quo2), .neg (neg2)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			degen_dly_q[0] <= degen_in;
			for (int k = 1; k < DIV_STAGES; k++) begin
				degen_dly_q[k] <= degen_dly_q[k-1];
			end
		end
	end

	function automatic weight_t sat_quo(input logic [QUO_W-1:0] q, input logic n);
		logic [WEIGHT_W-1:0] lo;
		weight_t             w;
		lo = q[WEIGHT_W-1:0];
		if (n) begin
			if (q[QUO_W-1] || (lo > WEIGHT_W'(W_MIN))) begin
				w = W_MIN;
			end else begin
				w = -$signed(lo);
			end
		end else begin
			if (q[QUO_W-1] || lo[WEIGHT_W-1]) begin
				w = W_MAX;
			end else begin
				w = $signed(lo);
			end
		end
		return w;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			w1_s43    <= sat_quo(quo1, neg1);
			w2_s43    <= sat_quo(quo2, neg2);
			degen_s43 <= degen_dly_q[DIV_STAGES-1];
		end
	end

	assign w0_sum = ONE_EXT - (WEIGHT_W+2)'(w1_s43) - (WEIGHT_W+2)'(w2_s43);

	always_ff @(posedge clk) begin
		if (en) begin
			out_s44.degenerate <= degen_s43;
			if (degen_s43) begin
				out_s44.weight0 <= '0;
				out_s44.weight1 <= '0;
				out_s44.weight2 <= '0;
			end else begin
				out_s44.weight1 <= w1_s43;
				out_s44.weight2 <= w2_s43;
				if (w0_sum > (WEIGHT_W+2)'(W_MAX)) begin
					out_s44.weight0 <= W_MAX;
				end else if (w0_sum < (WEIGHT_W+2)'(W_MIN)) begin
					out_s44.weight0 <= W_MIN;
				end else begin
					out_s44.weight0 <= w0_sum[WEIGHT_W-1:0];
				end
			end
		end
	end

	assign weights.valid = valid_q[PIPE_DEPTH-1];
	assign weights.data  = out_s44;

	// a degenerate triangle never leaks partial weights
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		weights.valid && weights.data.degenerate |->
		weights.data.weight0 == '0 && weights.data.weight1 == '0 &&
		weights.data.weight2 == '0)
		else $error("degenerate item with non-zero weights");

	// while stalled the valid bits of every stage hold
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_q))
		else $error("pipeline moved during a stall");

	// unsaturated weights sum to one
	a_sum_one: assert property (@(posedge clk) disable iff (!arst_n)
		weights.valid && !weights.data.degenerate &&
		weights.data.weight0 != W_MAX && weights.data.weight0 != W_MIN &&
		weights.data.weight1 != W_MAX && weights.data.weight1 != W_MIN &&
		weights.data.weight2 != W_MAX && weights.data.weight2 != W_MIN |->
		(WEIGHT_W+2)'(weights.data.weight0) + (WEIGHT_W+2)'(weights.data.weight1)
		+ (WEIGHT_W+2)'(weights.data.weight2) == ONE_EXT)
		else $error("weights do not sum to one");

endmodule

[rtl/tbw_dot.sv]
// edge vectors from corner 0 and the five dot products, three stages
module tbw_dot import tbw_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  tbw_query_t q,
	output dot_t       d11,
	output dot_t       d12,
	output dot_t       d1p,
	output dot_t       d22,
	output dot_t       d2p
);

	coord_t pt [3];
	coord_t c0 [3];
	coord_t c1 [3];
	coord_t c2 [3];

	logic signed [DIFF_W-1:0] vp_s1 [3];
	logic signed [DIFF_W-1:0] v1_s1 [3];
	logic signed [DIFF_W-1:0] v2_s1 [3];

	logic signed [PROD_W-1:0] p11_s2 [3];
	logic signed [PROD_W-1:0] p12_s2 [3];
	logic signed [PROD_W-1:0] p1p_s2 [3];
	logic signed [PROD_W-1:0] p22_s2 [3];
	logic signed [PROD_W-1:0] p2p_s2 [3];

	dot_t d11_s3, d12_s3, d1p_s3, d22_s3, d2p_s3;

	always_comb begin
		pt[0] = q.point_x;   pt[1] = q.point_y;   pt[2] = q.point_z;
		c0[0] = q.corner0_x; c0[1] = q.corner0_y; c0[2] = q.corner0_z;
		c1[0] = q.corner1_x; c1[1] = q.corner1_y; c1[2] = q.corner1_z;
		c2[0] = q.corner2_x; c2[1] = q.corner2_y; c2[2] = q.corner2_z;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				vp_s1[k] <= DIFF_W'(pt[k]) - DIFF_W'(c0[k]);
				v1_s1[k] <= DIFF_W'(c1[k]) - DIFF_W'(c0[k]);
				v2_s1[k] <= DIFF_W'(c2[k]) - DIFF_W'(c0[k]);
			end
			for (int k = 0; k < 3; k++) begin
				p11_s2[k] <= v1_s1[k] * v1_s1[k];
				p12_s2[k] <= v1_s1[k] * v2_s1[k];
				p1p_s2[k] <= v1_s1[k] * vp_s1[k];
				p22_s2[k] <= v2_s1[k] * v2_s1[k];
				p2p_s2[k] <= v2_s1[k] * vp_s1[k];
			end
			d11_s3 <= DOT_W'(p11_s2[0]) + DOT_W'(p11_s2[1]) + DOT_W'(p11_s2[2]);
			d12_s3 <= DOT_W'(p12_s2[0]) + DOT_W'(p12_s2[1]) + DOT_W'(p12_s2[2]);
			d1p_s3 <= DOT_W'(p1p_s2[0]) + DOT_W'(p1p_s2[1]) + DOT_W'(p1p_s2[2]);
			d22_s3 <= DOT_W'(p22_s2[0]) + DOT_W'(p22_s2[1]) + DOT_W'(p22_s2[2]);
			d2p_s3 <= DOT_W'(p2p_s2[0]) + DOT_W'(p2p_s2[1]) + DOT_W'(p2p_s2[2]);
		end
	end

	assign d11 = d11_s3;
	assign d12 = d12_s3;
	assign d1p = d1p_s3;
	assign d22 = d22_s3;
	assign d2p = d2p_s3;

endmodule

[rtl/tbw_mul.sv]
// signed product of two dot products, split into half-width partial products
module tbw_mul import tbw_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  dot_t  a,
	input  dot_t  b,
	output smul_t p
);

	logic [HALF_W-1:0] alo_s1, ahi_s1, blo_s1, bhi_s1;
	logic              neg_s1, neg_s2, neg_s3;
	logic [PART_W-1:0] ll_s2, lh_s2, hl_s2, hh_s2;
	logic [DEN_W-1:0]  mag_s3;
	smul_t             p_s4;
	logic [MAG_W-1:0]  amag, bmag;
	logic [2*PART_W-1:0] sum;

	always_comb begin
		amag = a[DOT_W-1] ? MAG_W'(-a) : MAG_W'(a);
		bmag = b[DOT_W-1] ? MAG_W'(-b) : MAG_W'(b);
		sum = {hh_s2, ll_s2}
			+ ((2*PART_W)'(lh_s2) << HALF_W)
			+ ((2*PART_W)'(hl_s2) << HALF_W);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alo_s1 <= amag[HALF_W-1:0];
			ahi_s1 <= HALF_W'(amag >> HALF_W);
			blo_s1 <= bmag[HALF_W-1:0];
			bhi_s1 <= HALF_W'(bmag >> HALF_W);
			neg_s1 <= a[DOT_W-1] ^ b[DOT_W-1];

			ll_s2  <= alo_s1 * blo_s1;
			lh_s2  <= alo_s1 * bhi_s1;
			hl_s2  <= ahi_s1 * blo_s1;
			hh_s2  <= ahi_s1 * bhi_s1;
			neg_s2 <= neg_s1;

			mag_s3 <= sum[DEN_W-1:0];
			neg_s3 <= neg_s2;

			p_s4 <= neg_s3 ? -SMUL_W'(mag_s3) : SMUL_W'(mag_s3);
		end
	end

	assign p = p_s4;

endmodule

[rtl/tbw_div.sv]
// restoring divider, one quotient bit per stage, top bit flags overflow
module tbw_div import tbw_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [NMAG_W-1:0] num_mag,
	input  logic              num_neg,
	input  logic [DEN_W-1:0]  den,
	output logic [QUO_W-1:0]  quo,
	output logic              neg
);

	logic [REM_W-1:0] rem_s [0:QUO_W-1];
	logic [DEN_W-1:0] den_s [0:QUO_W-1];
	logic [QUO_W-1:0] quo_s [0:QUO_W];
	logic             neg_s [0:QUO_W];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= REM_W'(num_mag) << FRAC_BITS;
			den_s[0] <= den;
			quo_s[0] <= '0;
			neg_s[0] <= num_neg;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		localparam int BIT = QUO_W - 1 - k;
		logic [REM_W:0] trial;

		assign trial = {1'b0, rem_s[k]} - ((REM_W+1)'(den_s[k]) << BIT);

		if (k < QUO_W - 1) begin : g_mid
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= trial[REM_W] ? rem_s[k] : trial[REM_W-1:0];
					den_s[k+1] <= den_s[k];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k+1] <= quo_s[k] | (trial[REM_W] ? '0 : (QUO_W'(1) << BIT));
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign quo = quo_s[QUO_W];
	assign neg = neg_s[QUO_W];

endmodule
